>>> design/grid_hit_counter_region_scan_core_assert.svh
// Assertion macros for the grid hit counter region scan core.
// Depends on nothing; included by the top-level core, the only module that asserts.
`ifndef GRID_HIT_COUNTER_REGION_SCAN_CORE_ASSERT_SVH
`define GRID_HIT_COUNTER_REGION_SCAN_CORE_ASSERT_SVH

// Same-cycle implication.
`define GHRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GHRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ghrs_pkg.sv
// Shared constants and types for the grid hit counter region scan core.
// Depends on nothing.
package ghrs_pkg;

   localparam int COORD_W       = 3;
   localparam int COUNT_W       = 16;
   localparam int GRID_SIZE_DEF = 8;

   localparam logic [COUNT_W-1:0] CELL_MAX = '1;

   localparam logic MODE_INC = 1'b0;
   localparam logic MODE_QRY = 1'b1;

   // Port controls of the counter memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

>>> design/ghrs_mem.sv
// Counter memory: one write port, one registered read port, per-entry valid bits.
// Depends on ghrs_pkg.
module ghrs_mem
   import ghrs_pkg::*;
#(
   parameter int DEPTH  = GRID_SIZE_DEF * GRID_SIZE_DEF,
   parameter int ADDR_W = $clog2(GRID_SIZE_DEF * GRID_SIZE_DEF)
) (
   input  logic               clock,
   input  logic               reset,
   input  mem_ctl_type        mem_ctl,
   input  logic [ADDR_W-1:0]  rd_addr,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [COUNT_W-1:0] wr_data,
   output logic [COUNT_W-1:0] rd_data
);

   logic [COUNT_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic [COUNT_W-1:0] rd_data_ff;
   logic               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_ctl.wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

>>> design/grid_hit_counter_region_scan_core.sv
// Top level of the grid hit counter region scan core: sequencer and result stage.
// Depends on ghrs_pkg, ghrs_mem and grid_hit_counter_region_scan_core_assert.svh.
//
//  channel | ports  | direction | beat carries
//  --------+--------+-----------+------------------------------------------
//  request | req_*  | in        | mode, row, col, row_end, col_end
//  result  | rsp_*  | out       | hit_row, hit_col, hit_count, last
//
// Increment: a read of the counter memory in ST_IDLE, then a write back in ST_INC_WR.
// Query: the accept issues the first read, then one cell per cycle, unless stalled, across the
//   rectangle (up to GRID_SIZE*GRID_SIZE cells), then ST_FLUSH releases the final hit.
//   The single read port of the counter memory sets the one-cell-a-cycle pace.
// A found cell waits in a hold register until the next hit or the scan end
//   decides its last flag; the scan stalls on a hit cell when hold and output are full.
// Reset clears the per-entry valid bits; no clearing pass.
module grid_hit_counter_region_scan_core
   import ghrs_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [COORD_W-1:0] req_row,
   input  logic [COORD_W-1:0] req_col,
   input  logic [COORD_W-1:0] req_row_end,
   input  logic [COORD_W-1:0] req_col_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COORD_W-1:0] rsp_hit_row,
   output logic [COORD_W-1:0] rsp_hit_col,
   output logic [COUNT_W-1:0] rsp_hit_count,
   output logic               rsp_last
);

`include "grid_hit_counter_region_scan_core_assert.svh"

   localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [COORD_W:0]   GRID_LIM  = (COORD_W+1)'(GRID_SIZE);
   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INC_WR,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
      return ADDR_W'(int'(r) * GRID_SIZE + int'(c));
   endfunction

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  inc_addr_ff, inc_addr_in;
   logic [COORD_W-1:0] scan_row_ff, scan_row_in;
   logic [COORD_W-1:0] scan_col_ff, scan_col_in;
   logic [COORD_W-1:0] start_col_ff, start_col_in;
   logic [COORD_W-1:0] end_row_ff, end_row_in;
   logic [COORD_W-1:0] end_col_ff, end_col_in;
   logic               hold_valid_ff, hold_valid_in;
   logic [COORD_W-1:0] hold_row_ff, hold_row_in;
   logic [COORD_W-1:0] hold_col_ff, hold_col_in;
   logic [COUNT_W-1:0] hold_count_ff, hold_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COORD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   mem_ctl_type        mem_ctl;
   logic [ADDR_W-1:0]  rd_addr;
   logic [COUNT_W-1:0] rd_data;
   logic [COUNT_W-1:0] wr_data;

   logic               accept;
   logic               row_ok, col_ok, query_ok;
   logic [COORD_W-1:0] row_end_clamp, col_end_clamp;
   logic               out_free, hit, at_end, absorb;
   logic [COORD_W-1:0] next_row, next_col;

   ghrs_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (inc_addr_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // out-of-grid checks; ends beyond the grid clamp to its edge
   assign row_ok        = ({1'b0, req_row} < GRID_LIM);
   assign col_ok        = ({1'b0, req_col} < GRID_LIM);
   assign row_end_clamp = ({1'b0, req_row_end} < GRID_LIM) ? req_row_end : COORD_MAX;
   assign col_end_clamp = ({1'b0, req_col_end} < GRID_LIM) ? req_col_end : COORD_MAX;
   assign query_ok      = row_ok && col_ok && (req_row <= row_end_clamp)
                          && (req_col <= col_end_clamp);

   // saturating increment of the counter read in the previous cycle
   assign wr_data = (rd_data == CELL_MAX) ? rd_data : rd_data + COUNT_W'(1);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hit      = (rd_data != '0);
   assign at_end   = (scan_row_ff == end_row_ff) && (scan_col_ff == end_col_ff);
   // a hit needs room only when the held hit must move to the output
   assign absorb   = !hit || !hold_valid_ff || out_free;

   // row-major step through the rectangle
   always_comb begin
      if (scan_col_ff == end_col_ff) begin
         next_row = scan_row_ff + COORD_W'(1);
         next_col = start_col_ff;
      end else begin
         next_row = scan_row_ff;
         next_col = scan_col_ff + COORD_W'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      inc_addr_in   = inc_addr_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      start_col_in  = start_col_ff;
      end_row_in    = end_row_ff;
      end_col_in    = end_col_ff;
      hold_valid_in = hold_valid_ff;
      hold_row_in   = hold_row_ff;
      hold_col_in   = hold_col_ff;
      hold_count_in = hold_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      mem_ctl       = '0;
      rd_addr       = cell_addr(req_row, req_col);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_INC) begin
                  if (row_ok && col_ok) begin
                     mem_ctl.rd_en = 1'b1;
                     inc_addr_in   = cell_addr(req_row, req_col);
                     state_in      = ST_INC_WR;
                  end
               end else if (query_ok) begin
                  mem_ctl.rd_en = 1'b1;
                  scan_row_in   = req_row;
                  scan_col_in   = req_col;
                  start_col_in  = req_col;
                  end_row_in    = row_end_clamp;
                  end_col_in    = col_end_clamp;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_INC_WR: begin
            mem_ctl.wr_en = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            if (absorb) begin
               if (hit) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in   = hold_row_ff;
                     rsp_col_in   = hold_col_ff;
                     rsp_count_in = hold_count_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_row_in   = scan_row_ff;
                  hold_col_in   = scan_col_ff;
                  hold_count_in = rd_data;
               end
               if (at_end) begin
                  state_in = ST_FLUSH;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = cell_addr(next_row, next_col);
                  scan_row_in   = next_row;
                  scan_col_in   = next_col;
               end
            end else begin
               // stalled: re-read the same cell next cycle
               mem_ctl.rd_en = 1'b1;
               rd_addr       = cell_addr(scan_row_ff, scan_col_ff);
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = hold_row_ff;
               rsp_col_in    = hold_col_ff;
               rsp_count_in  = hold_count_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff      <= state_in;
      inc_addr_ff   <= inc_addr_in;
      scan_row_ff   <= scan_row_in;
      scan_col_ff   <= scan_col_in;
      start_col_ff  <= start_col_in;
      end_row_ff    <= end_row_in;
      end_col_ff    <= end_col_in;
      hold_valid_ff <= hold_valid_in;
      hold_row_ff   <= hold_row_in;
      hold_col_ff   <= hold_col_in;
      hold_count_ff <= hold_count_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit_row   = rsp_row_ff;
   assign rsp_hit_col   = rsp_col_ff;
   assign rsp_hit_count = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   `GHRS_ASSERT_NOW(a_idle_no_hold, clock, reset, state_ff == ST_IDLE, !hold_valid_ff,
      "held hit left behind after a scan")
   `GHRS_ASSERT_NOW(a_no_rw_overlap, clock, reset, mem_ctl.wr_en, !mem_ctl.rd_en,
      "counter memory read and written in one cycle")
   `GHRS_ASSERT_NOW(a_hit_nonzero, clock, reset, rsp_valid, rsp_hit_count != '0,
      "result beat with zero count")
   `GHRS_ASSERT_NOW(a_scan_in_rect, clock, reset, state_ff == ST_SCAN,
      (scan_row_ff <= end_row_ff) && (scan_col_ff <= end_col_ff)
      && (scan_col_ff >= start_col_ff), "scan pointer outside rectangle")
   `GHRS_ASSERT_NEXT(a_inc_returns, clock, reset, state_ff == ST_INC_WR,
      state_ff == ST_IDLE, "increment write back did not finish")

endmodule

>>> dv/ghrs_hit_tracker.sv
// Checker for the grid hit counter region scan core: keeps its own copy of the hit
// grid, works out each query's hit beats and compares them with the result channel.
// Depends on ghrs_pkg.
module ghrs_hit_tracker
   import ghrs_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_mode,
   input  logic [COORD_W-1:0] req_row,
   input  logic [COORD_W-1:0] req_col,
   input  logic [COORD_W-1:0] req_row_end,
   input  logic [COORD_W-1:0] req_col_end,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [COORD_W-1:0] rsp_hit_row,
   input  logic [COORD_W-1:0] rsp_hit_col,
   input  logic [COUNT_W-1:0] rsp_hit_count,
   input  logic               rsp_last,
   output int                 mismatches,
   output int                 outstanding,
   output int                 req_beats,
   output int                 query_beats,
   output int                 hit_beats
);

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COUNT_W-1:0] count;
      logic               last;
   } hit_rec_type;

   logic [COUNT_W-1:0] cell_hits [0:GRID_SIZE*GRID_SIZE-1];
   hit_rec_type        hits_due [$];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t hit check: %s is %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic bump_cell(input int r, input int c);
      int k;
      if (r < GRID_SIZE && c < GRID_SIZE) begin
         k = r * GRID_SIZE + c;
         if (cell_hits[k] != CELL_MAX) cell_hits[k] = cell_hits[k] + COUNT_W'(1);
      end
   endtask

   // Row-major walk; each hit is held back one step so the final one gets last.
   task automatic scan_rectangle(input int r0, input int c0, input int r1, input int c1);
      hit_rec_type held;
      bit          have_held;
      have_held = 1'b0;
      if (r0 >= GRID_SIZE || c0 >= GRID_SIZE) return;
      if (r1 >= GRID_SIZE) r1 = GRID_SIZE - 1;
      if (c1 >= GRID_SIZE) c1 = GRID_SIZE - 1;
      if (r0 > r1 || c0 > c1) return;
      for (int r = r0; r <= r1; r++) begin
         for (int c = c0; c <= c1; c++) begin
            if (cell_hits[r * GRID_SIZE + c] != '0) begin
               if (have_held) hits_due.push_back(held);
               held.row   = COORD_W'(r);
               held.col   = COORD_W'(c);
               held.count = cell_hits[r * GRID_SIZE + c];
               held.last  = 1'b0;
               have_held  = 1'b1;
            end
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         hits_due.push_back(held);
      end
   endtask

   always @(posedge clock) begin
      hit_rec_type want;
      if (reset) begin
         foreach (cell_hits[k]) cell_hits[k] = '0;
         hits_due.delete();
      end else begin
         // Result side first: a query's hits can never leave on its own accept edge.
         if (rsp_valid && rsp_ready) begin
            hit_beats++;
            if (hits_due.size() == 0) begin
               report("unexpected hit beat, hit_count", 32'(rsp_hit_count), 32'd0);
            end else begin
               want = hits_due.pop_front();
               if (rsp_hit_row !== want.row)
                  report("hit_row", 32'(rsp_hit_row), 32'(want.row));
               if (rsp_hit_col !== want.col)
                  report("hit_col", 32'(rsp_hit_col), 32'(want.col));
               if (rsp_hit_count !== want.count)
                  report("hit_count", 32'(rsp_hit_count), 32'(want.count));
               if (rsp_last !== want.last) report("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (req_valid && req_ready) begin
            req_beats++;
            if (req_mode == MODE_INC) begin
               bump_cell(int'(req_row), int'(req_col));
            end else begin
               query_beats++;
               scan_rectangle(int'(req_row), int'(req_col), int'(req_row_end),
                              int'(req_col_end));
            end
         end
      end
      outstanding = hits_due.size();
   end

endmodule

>>> dv/grid_hit_counter_region_scan_core_test.sv
// Top of the grid hit counter region scan core testbench: clock, reset, request
// and result stimulus, watchdog and verdict; checking lives in ghrs_hit_tracker.
// Depends on ghrs_pkg, ghrs_hit_tracker and grid_hit_counter_region_scan_core.
module grid_hit_counter_region_scan_core_test;
   import ghrs_pkg::*;

   localparam int STALL_LIMIT  = 2000;   // cycles with no beat on either channel
   localparam int LONG_HOLD    = 400;    // result side held off to back up the core
   localparam int DRAIN_CYCLES = 100;    // > one full 64-cell scan plus overhead
   localparam int RANDOM_ITEMS = 420;
   localparam int HOT_BEATS    = 20;     // back-to-back increments on one cell

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = MODE_INC;
   logic [COORD_W-1:0] req_row = '0;
   logic [COORD_W-1:0] req_col = '0;
   logic [COORD_W-1:0] req_row_end = '0;
   logic [COORD_W-1:0] req_col_end = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [COORD_W-1:0] rsp_hit_row;
   logic [COORD_W-1:0] rsp_hit_col;
   logic [COUNT_W-1:0] rsp_hit_count;
   logic               rsp_last;

   int mismatches, outstanding, req_beats, query_beats, hit_beats;
   int quiet_cycles = 0;
   int hold_asks = 0;     // bumped by the request side to ask for one long hold-off
   int hold_seen = 0;
   bit calm_req = 1'b0;   // no gaps between request beats while set
   bit calm_rsp = 1'b0;   // result side always ready while set

   always #5 clock = ~clock;

   grid_hit_counter_region_scan_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_row_end   (req_row_end),
      .req_col_end   (req_col_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit_row   (rsp_hit_row),
      .rsp_hit_col   (rsp_hit_col),
      .rsp_hit_count (rsp_hit_count),
      .rsp_last      (rsp_last)
   );

   ghrs_hit_tracker tracker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_row_end   (req_row_end),
      .req_col_end   (req_col_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit_row   (rsp_hit_row),
      .rsp_hit_col   (rsp_hit_col),
      .rsp_hit_count (rsp_hit_count),
      .rsp_last      (rsp_last),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .req_beats     (req_beats),
      .query_beats   (query_beats),
      .hit_beats     (hit_beats)
   );

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Present one request beat at a falling edge and hold it until it is taken.
   // Valid stays high on return so a zero gap keeps the channel busy.
   task automatic offer(input logic mode, input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                        input logic [COORD_W-1:0] r_end, input logic [COORD_W-1:0] c_end);
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_row     <= r;
      req_col     <= c;
      req_row_end <= r_end;
      req_col_end <= c_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic rest(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   task automatic random_beat();
      logic [COORD_W-1:0] a, b, c, d, t;
      int roll;
      roll = $urandom_range(0, 99);
      a = COORD_W'($urandom);
      b = COORD_W'($urandom);
      c = COORD_W'($urandom);
      d = COORD_W'($urandom);
      if (roll < 55) begin
         offer(MODE_INC, a, b, c, d);
      end else if (roll < 80) begin
         // well-formed rectangle
         if (a > c) begin t = a; a = c; c = t; end
         if (b > d) begin t = b; b = d; d = t; end
         offer(MODE_QRY, a, b, c, d);
      end else if (roll < 88) begin
         // single cell or single row
         offer(MODE_QRY, a, b, a, (roll < 84) ? b : d);
      end else begin
         // anything, inverted rectangles included
         offer(MODE_QRY, a, b, c, d);
      end
      rest(calm_req ? 0 : pick_gap());
   endtask

   // Result side: random stalls, calm stretches and the one long hold-off.
   initial begin : result_side
      int stall;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         stall = calm_rsp ? 0 : pick_gap();
         if (stall == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   // Watchdog: any beat on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d hits still due", quiet_cycles,
                  outstanding);
         $display("grid_hit_counter_region_scan_core_test: errors");
         $finish;
      end
   end

   initial begin : request_side
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: corners, double hit, empty area, inverted and degenerate rectangles.
      offer(MODE_QRY, 3'd0, 3'd0, 3'd7, 3'd7);   // grid empty after reset
      rest(pick_gap());
      offer(MODE_INC, 3'd0, 3'd0, 3'd7, 3'd7);
      rest(pick_gap());
      offer(MODE_INC, 3'd0, 3'd0, 3'd0, 3'd0);
      rest(pick_gap());
      offer(MODE_INC, 3'd7, 3'd7, 3'd0, 3'd0);
      rest(pick_gap());
      offer(MODE_INC, 3'd0, 3'd7, 3'd5, 3'd2);
      rest(pick_gap());
      offer(MODE_INC, 3'd7, 3'd0, 3'd2, 3'd5);
      rest(pick_gap());
      offer(MODE_INC, 3'd3, 3'd4, 3'd7, 3'd7);
      rest(pick_gap());
      offer(MODE_QRY, 3'd0, 3'd0, 3'd7, 3'd7);   // all five hits, last on the corner
      rest(pick_gap());
      offer(MODE_QRY, 3'd0, 3'd0, 3'd0, 3'd0);
      rest(pick_gap());
      offer(MODE_QRY, 3'd7, 3'd7, 3'd7, 3'd7);
      rest(pick_gap());
      offer(MODE_QRY, 3'd5, 3'd0, 3'd2, 3'd7);   // rows inverted
      rest(pick_gap());
      offer(MODE_QRY, 3'd0, 3'd5, 3'd7, 3'd2);   // columns inverted
      rest(pick_gap());
      offer(MODE_QRY, 3'd1, 3'd1, 3'd2, 3'd2);   // nothing there
      rest(pick_gap());
      offer(MODE_QRY, 3'd0, 3'd0, 3'd0, 3'd7);
      rest(pick_gap());
      offer(MODE_QRY, 3'd0, 3'd7, 3'd7, 3'd7);
      rest(pick_gap());
      offer(MODE_INC, 3'd7, 3'd7, 3'd7, 3'd7);
      rest(pick_gap());
      offer(MODE_QRY, 3'd6, 3'd6, 3'd7, 3'd7);
      rest(pick_gap());
      offer(MODE_QRY, 3'd3, 3'd4, 3'd3, 3'd4);
      settle();

      // Hot cell: back-to-back increments of one counter, then read it back.
      calm_rsp = 1'b1;
      repeat (HOT_BEATS) offer(MODE_INC, 3'd2, 3'd5, 3'd0, 3'd0);
      offer(MODE_QRY, 3'd2, 3'd5, 3'd2, 3'd5);
      offer(MODE_QRY, 3'd0, 3'd0, 3'd7, 3'd7);
      calm_rsp = 1'b0;
      settle();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            calm_req = ($urandom_range(0, 3) == 0);
            calm_rsp = ($urandom_range(0, 5) == 0);
         end
         if (i == 150) begin
            // Hold the result side off and keep offering full-grid scans so the
            // core backs up and drops req_ready.
            hold_asks++;
            repeat (12) offer(MODE_QRY, 3'd0, 3'd0, 3'd7, 3'd7);
         end
         if (i == 300) settle();
         random_beat();
      end
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request beats (%0d scans) and %0d hit beats,", req_beats,
               query_beats, hit_beats);
      $display("with a hot cell hit back to back and a long result-side hold-off");
      if (mismatches == 0) begin
         $display("grid_hit_counter_region_scan_core_test: clean");
      end else begin
         $display("grid_hit_counter_region_scan_core_test: errors");
      end
      $finish;
   end

endmodule
